// ----- rtl/core/bctd_pkg.sv -----
// shared types, codes and texel math for the bc texture block decoder
package bctd_pkg;

  localparam int WORD_W     = 64;
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int NUM_W      = 11;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // format codes
  localparam logic [MODE_W-1:0] MODE_DXT1  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DXT3  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DXT5  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LATC1 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LATC2 = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // divisor codes carried between the select and finish stages
  localparam logic [1:0] DIV_ONE   = 2'd0;
  localparam logic [1:0] DIV_THREE = 2'd1;
  localparam logic [1:0] DIV_FIVE  = 2'd2;
  localparam logic [1:0] DIV_SEVEN = 2'd3;

  // reciprocals scaled by 2^14, exact floor for numerators below 2048
  localparam int          RECIP_SHIFT = 14;
  localparam logic [14:0] RECIP_ONE   = 15'd16384;
  localparam logic [14:0] RECIP_THREE = 15'd5462;
  localparam logic [14:0] RECIP_FIVE  = 15'd3277;
  localparam logic [14:0] RECIP_SEVEN = 15'd2341;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [1:0]       div;
  } chan_num_t;

  // one complete block handed from the walker to the emitter
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [WORD_W-1:0]  first;
    logic [WORD_W-1:0]  second;
    logic [COORD_W-1:0] base_x;
    logic [COORD_W-1:0] base_y;
    logic [1:0]         cw_m1;
    logic [1:0]         ch_m1;
  } blk_t;

  // texel after selection, before the divide
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    chan_num_t          c0;
    chan_num_t          c1;
    chan_num_t          c2;
    chan_num_t          c3;
    logic               last;
  } texel_pre_t;

  // 8- or 6-value interpolation numerator for texel t
  function automatic chan_num_t interp_num(logic [WORD_W-1:0] w, logic [3:0] t);
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [2:0]       k;
    logic [NUM_W-1:0] f0;
    logic [NUM_W-1:0] f1;
    chan_num_t        r;
    a0 = w[7:0];
    a1 = w[15:8];
    k  = w[16 + 3 * t +: 3];
    f1 = NUM_W'(k) - NUM_W'(1);
    r.div = DIV_ONE;
    r.num = '0;
    if (k == 3'd0) begin
      r.num = NUM_W'(a0);
    end else if (k == 3'd1) begin
      r.num = NUM_W'(a1);
    end else if (a0 > a1) begin
      f0    = NUM_W'(8) - NUM_W'(k);
      r.num = f0 * NUM_W'(a0) + f1 * NUM_W'(a1);
      r.div = DIV_SEVEN;
    end else if (k == 3'd6) begin
      r.num = '0;
    end else if (k == 3'd7) begin
      r.num = NUM_W'(255);
    end else begin
      f0    = NUM_W'(6) - NUM_W'(k);
      r.num = f0 * NUM_W'(a0) + f1 * NUM_W'(a1);
      r.div = DIV_FIVE;
    end
    return r;
  endfunction

  // colour channel ci (0 red, 1 green, 2 blue) numerator for texel t
  function automatic chan_num_t colour_num(logic [WORD_W-1:0] w, logic [3:0] t,
                                           logic four, logic [1:0] ci);
    logic [15:0]      c0;
    logic [15:0]      c1;
    logic [NUM_W-1:0] e0;
    logic [NUM_W-1:0] e1;
    logic [1:0]       sel;
    logic [NUM_W-1:0] half;
    chan_num_t        r;
    c0  = w[15:0];
    c1  = w[31:16];
    sel = w[32 + 2 * t +: 2];
    case (ci)
      2'd0: begin
        e0 = NUM_W'({c0[15:11], 3'b000});
        e1 = NUM_W'({c1[15:11], 3'b000});
      end
      2'd1: begin
        e0 = NUM_W'({c0[10:5], 2'b00});
        e1 = NUM_W'({c1[10:5], 2'b00});
      end
      default: begin
        e0 = NUM_W'({c0[4:0], 3'b000});
        e1 = NUM_W'({c1[4:0], 3'b000});
      end
    endcase
    half  = (e0 + e1 + NUM_W'(1)) >> 1;
    r.div = DIV_ONE;
    if (sel == 2'd0) begin
      r.num = e0;
    end else if (sel == 2'd1) begin
      r.num = e1;
    end else if (four || (c0 > c1)) begin
      r.div = DIV_THREE;
      if (sel == 2'd2) begin
        r.num = (e0 << 1) + e1 + NUM_W'(1);
      end else begin
        r.num = e0 + (e1 << 1) + NUM_W'(1);
      end
    end else if (sel == 2'd2) begin
      r.num = half;
    end else begin
      r.num = '0;
    end
    return r;
  endfunction

  // divide by the small constant through its scaled reciprocal
  function automatic logic [CHAN_W-1:0] chan_finish(chan_num_t c);
    logic [14:0] recip;
    logic [25:0] p;
    unique case (c.div)
      DIV_ONE:   recip = RECIP_ONE;
      DIV_THREE: recip = RECIP_THREE;
      DIV_FIVE:  recip = RECIP_FIVE;
      default:   recip = RECIP_SEVEN;
    endcase
    p = 26'(c.num) * 26'(recip);
    return p[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

// ----- rtl/core/bctd_if.sv -----
// channel interfaces: compressed words in, texels out, configuration writes
interface bctd_word_if;
  logic                          valid;
  logic                          ready;
  logic [bctd_pkg::WORD_W-1:0]   block_word;
  modport source (output valid, output block_word, input ready);
  modport sink (input valid, input block_word, output ready);
endinterface

interface bctd_texel_if;
  logic                          valid;
  logic                          ready;
  logic [bctd_pkg::COORD_W-1:0]  texel_x;
  logic [bctd_pkg::COORD_W-1:0]  texel_y;
  logic [bctd_pkg::CHAN_W-1:0]   chan_red_or_lum;
  logic [bctd_pkg::CHAN_W-1:0]   chan_green_or_second;
  logic [bctd_pkg::CHAN_W-1:0]   chan_blue;
  logic [bctd_pkg::CHAN_W-1:0]   chan_alpha;
  logic                          block_last;
  modport source (output valid, output texel_x, output texel_y, output chan_red_or_lum,
                  output chan_green_or_second, output chan_blue, output chan_alpha,
                  output block_last, input ready);
  modport sink (input valid, input texel_x, input texel_y, input chan_red_or_lum,
                input chan_green_or_second, input chan_blue, input chan_alpha,
                input block_last, output ready);
endinterface

interface bctd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bctd_pkg::CFG_IDX_W-1:0]  index;
  logic [bctd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/bctd_walker.sv -----
// configuration registers, two-word assembly and raster block walk
module bctd_walker #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst,
  bctd_cfg_if.sink            cfg,
  bctd_word_if.sink           words,
  output logic                blk_valid,
  input  logic                blk_ready,
  output bctd_pkg::blk_t      blk
);

  localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
  localparam int BLK_W = DIM_W - 2;
  localparam int CMP_W = (DIM_W > bctd_pkg::CFG_DATA_W) ? DIM_W : bctd_pkg::CFG_DATA_W;
  localparam int XW    = (DIM_W > bctd_pkg::COORD_W) ? DIM_W : bctd_pkg::COORD_W;

  logic [bctd_pkg::MODE_W-1:0] mode;
  logic [DIM_W-1:0]            w_dim;
  logic [DIM_W-1:0]            h_dim;
  logic [bctd_pkg::WORD_W-1:0] held_word;
  logic                        phase;
  logic [BLK_W-1:0]            col;
  logic [BLK_W-1:0]            row;

  logic                        cfg_wr;
  logic [CMP_W-1:0]            dv;
  logic [DIM_W-1:0]            dim_clamped;
  logic                        two_word;
  logic                        mode_ok;
  logic                        complete;
  logic                        accept;
  logic [DIM_W-1:0]            x0;
  logic [DIM_W-1:0]            y0;
  logic [DIM_W-1:0]            rem_x;
  logic [DIM_W-1:0]            rem_y;
  logic                        last_col;
  logic                        last_row;
  logic [XW-1:0]               x0_ext;
  logic [XW-1:0]               y0_ext;

  // configuration side never stalls
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  // clamp a written dimension into 1..MAX_IMAGE_DIM
  always_comb begin
    dv = CMP_W'(cfg.data);
    if (dv == '0) begin
      dim_clamped = DIM_W'(1);
    end else if (dv > CMP_W'(MAX_IMAGE_DIM)) begin
      dim_clamped = DIM_W'(MAX_IMAGE_DIM);
    end else begin
      dim_clamped = DIM_W'(dv);
    end
  end

  // block completion and input handshake
  assign two_word = (mode == bctd_pkg::MODE_DXT3) || (mode == bctd_pkg::MODE_DXT5) ||
                    (mode == bctd_pkg::MODE_LATC2);
  assign mode_ok  = (mode <= bctd_pkg::MODE_LATC2);
  assign complete = mode_ok && (!two_word || phase);
  assign words.ready = !complete || blk_ready;
  assign accept   = words.valid && words.ready;
  assign blk_valid = words.valid && complete;

  // block origin and clipped extent
  assign x0       = {col, 2'b00};
  assign y0       = {row, 2'b00};
  assign rem_x    = w_dim - x0;
  assign rem_y    = h_dim - y0;
  assign last_col = (rem_x <= DIM_W'(4));
  assign last_row = (rem_y <= DIM_W'(4));
  assign x0_ext   = XW'(x0);
  assign y0_ext   = XW'(y0);

  always_comb begin
    blk.mode   = mode;
    blk.first  = two_word ? held_word : words.block_word;
    blk.second = words.block_word;
    blk.base_x = x0_ext[bctd_pkg::COORD_W-1:0];
    blk.base_y = y0_ext[bctd_pkg::COORD_W-1:0];
    blk.cw_m1  = last_col ? (rem_x[1:0] - 2'd1) : 2'd3;
    blk.ch_m1  = last_row ? (rem_y[1:0] - 2'd1) : 2'd3;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= bctd_pkg::MODE_DXT1;
      w_dim <= DIM_W'(4);
      h_dim <= DIM_W'(4);
    end else if (cfg_wr) begin
      unique case (cfg.index)
        bctd_pkg::REG_FORMAT_MODE:  mode  <= cfg.data[bctd_pkg::MODE_W-1:0];
        bctd_pkg::REG_IMAGE_WIDTH:  w_dim <= dim_clamped;
        bctd_pkg::REG_IMAGE_HEIGHT: h_dim <= dim_clamped;
        default: ;
      endcase
    end
  end

  // held first word
  always_ff @(posedge clk) begin
    if (accept && two_word && !phase) begin
      held_word <= words.block_word;
    end
  end

  // word phase and block position
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      col   <= '0;
      row   <= '0;
    end else if (cfg_wr && (cfg.index == bctd_pkg::REG_FORMAT_MODE ||
                            cfg.index == bctd_pkg::REG_IMAGE_WIDTH ||
                            cfg.index == bctd_pkg::REG_IMAGE_HEIGHT)) begin
      phase <= 1'b0;
      col   <= '0;
      row   <= '0;
    end else if (accept && mode_ok) begin
      if (two_word && !phase) begin
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + BLK_W'(1);
        end else begin
          col <= col + BLK_W'(1);
        end
      end
    end
  end

  // walk stays inside the image
  assert property (@(posedge clk) disable iff (rst) (x0 < w_dim) && (y0 < h_dim))
    else $error("block origin outside image");

  // second-word phase only exists in a two-word format
  assert property (@(posedge clk) disable iff (rst) phase |-> two_word)
    else $error("word phase set in single-word format");

  // a first word moves the phase on
  assert property (@(posedge clk) disable iff (rst)
                   accept && two_word && !phase && !cfg_wr |=> phase)
    else $error("first word did not advance phase");

endmodule

// ----- rtl/core/bctd_emitter.sv -----
// block register, texel counter, texel decode and output register
module bctd_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                blk_valid,
  output logic                blk_ready,
  input  bctd_pkg::blk_t      blk_in,
  bctd_texel_if.source        texels
);

  bctd_pkg::blk_t      blk;
  logic                blk_vld;
  logic [1:0]          tx;
  logic [1:0]          ty;
  bctd_pkg::texel_pre_t pre;
  bctd_pkg::texel_pre_t pre_next;
  logic                pre_vld;
  logic                out_vld;

  logic                out_load;
  logic                pre_load;
  logic                texel_last;
  logic                blk_load;
  logic [3:0]          t;
  bctd_pkg::chan_num_t zero_num;
  bctd_pkg::chan_num_t full_num;

  // pipeline moves
  assign out_load   = pre_vld && (!out_vld || texels.ready);
  assign pre_load   = blk_vld && (!pre_vld || out_load);
  assign texel_last = (tx == blk.cw_m1) && (ty == blk.ch_m1);
  assign blk_ready  = !blk_vld || (pre_load && texel_last);
  assign blk_load   = blk_valid && blk_ready;
  assign t          = {ty, tx};

  assign zero_num = '{num: '0, div: bctd_pkg::DIV_ONE};
  assign full_num = '{num: bctd_pkg::NUM_W'(255), div: bctd_pkg::DIV_ONE};

  // texel select: numerators and divisor per channel
  always_comb begin
    pre_next.x    = blk.base_x + bctd_pkg::COORD_W'(tx);
    pre_next.y    = blk.base_y + bctd_pkg::COORD_W'(ty);
    pre_next.last = texel_last;
    pre_next.c0   = zero_num;
    pre_next.c1   = zero_num;
    pre_next.c2   = zero_num;
    pre_next.c3   = zero_num;
    unique case (blk.mode)
      bctd_pkg::MODE_DXT1: begin
        pre_next.c0 = bctd_pkg::colour_num(blk.first, t, 1'b0, 2'd0);
        pre_next.c1 = bctd_pkg::colour_num(blk.first, t, 1'b0, 2'd1);
        pre_next.c2 = bctd_pkg::colour_num(blk.first, t, 1'b0, 2'd2);
        pre_next.c3 = full_num;
      end
      bctd_pkg::MODE_DXT3: begin
        pre_next.c0 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd0);
        pre_next.c1 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd1);
        pre_next.c2 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd2);
        // times 17 is the nibble repeated
        pre_next.c3.num = bctd_pkg::NUM_W'({blk.first[4 * t +: 4], blk.first[4 * t +: 4]});
      end
      bctd_pkg::MODE_DXT5: begin
        pre_next.c0 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd0);
        pre_next.c1 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd1);
        pre_next.c2 = bctd_pkg::colour_num(blk.second, t, 1'b1, 2'd2);
        pre_next.c3 = bctd_pkg::interp_num(blk.first, t);
      end
      bctd_pkg::MODE_LATC1: begin
        pre_next.c0 = bctd_pkg::interp_num(blk.first, t);
      end
      bctd_pkg::MODE_LATC2: begin
        pre_next.c0 = bctd_pkg::interp_num(blk.second, t);
        pre_next.c1 = bctd_pkg::interp_num(blk.first, t);
      end
      default: ;
    endcase
  end

  // block register
  always_ff @(posedge clk) begin
    if (blk_load) begin
      blk <= blk_in;
    end
  end

  // block valid and texel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      blk_vld <= 1'b0;
      tx      <= '0;
      ty      <= '0;
    end else if (blk_load) begin
      blk_vld <= 1'b1;
      tx      <= '0;
      ty      <= '0;
    end else if (pre_load) begin
      if (texel_last) begin
        blk_vld <= 1'b0;
      end
      if (tx == blk.cw_m1) begin
        tx <= '0;
        ty <= ty + 2'd1;
      end else begin
        tx <= tx + 2'd1;
      end
    end
  end

  // select stage register
  always_ff @(posedge clk) begin
    if (pre_load) begin
      pre <= pre_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_vld <= 1'b0;
    end else if (pre_load) begin
      pre_vld <= 1'b1;
    end else if (out_load) begin
      pre_vld <= 1'b0;
    end
  end

  // output register with the divide
  always_ff @(posedge clk) begin
    if (out_load) begin
      texels.texel_x              <= pre.x;
      texels.texel_y              <= pre.y;
      texels.chan_red_or_lum      <= bctd_pkg::chan_finish(pre.c0);
      texels.chan_green_or_second <= bctd_pkg::chan_finish(pre.c1);
      texels.chan_blue            <= bctd_pkg::chan_finish(pre.c2);
      texels.chan_alpha           <= bctd_pkg::chan_finish(pre.c3);
      texels.block_last           <= pre.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= 1'b1;
    end else if (texels.ready) begin
      out_vld <= 1'b0;
    end
  end

  assign texels.valid = out_vld;

  // a new block starts at its first texel
  assert property (@(posedge clk) disable iff (rst)
                   blk_load |=> blk_vld && (tx == 2'd0) && (ty == 2'd0))
    else $error("block did not start at first texel");

  // counter stays inside the clipped block
  assert property (@(posedge clk) disable iff (rst)
                   blk_vld |-> (tx <= blk.cw_m1) && (ty <= blk.ch_m1))
    else $error("texel counter outside block");

  // select stage holds while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
                   pre_vld && out_vld && !texels.ready |=> pre_vld && $stable(pre))
    else $error("select stage lost a texel under stall");

endmodule

// ----- rtl/core/bc_texture_block_decoder_core.sv -----
// top level of the bc texture block decoder
//
//  channel   dir  handshake     beat payload
//  cfg       in   valid/ready   index (2), data (13)
//  blocks    in   valid/ready   block_word (64)
//  texels    out  valid/ready   texel_x, texel_y, four channels, block_last
//
// one texel leaves per cycle unless the texel receiver stalls or no block waits; a
// full 4x4 block gives 16 texels, a clipped block only the texels kept. the texel
// counter in the emitter sets this. a word that completes a block waits until the
// emitter takes the block; first words of two-word formats are taken at once. the
// completing word passes the block, select and output registers before its first
// texel. reset is synchronous and restores format 0 and a 4x4 image; cfg is always ready.
module bc_texture_block_decoder_core #(
  parameter int MAX_IMAGE_DIM = 4096
) (
  input  logic          clk,
  input  logic          rst,
  bctd_cfg_if.sink      cfg,
  bctd_word_if.sink     blocks,
  bctd_texel_if.source  texels
);

  logic           blk_valid;
  logic           blk_ready;
  bctd_pkg::blk_t blk;

  // word assembly and block walk
  bctd_walker #(
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .words     (blocks),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk)
  );

  // texel decode and output
  bctd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk_in    (blk),
    .texels    (texels)
  );

endmodule

// ----- sim/tb_bc_texture_block_decoder_core.sv -----
// self-checking testbench for the bc texture block decoder core
module tb_bc_texture_block_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM     = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RX_HOLD_LEN = 300;
  localparam int SETTLE      = 12;

  // codes the package leaves undefined
  localparam logic [bctd_pkg::MODE_W-1:0]    MODE_SPARE_6 = 3'd6;
  localparam logic [bctd_pkg::MODE_W-1:0]    MODE_SPARE_7 = 3'd7;
  localparam logic [bctd_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  typedef struct {
    logic [bctd_pkg::COORD_W-1:0] x;
    logic [bctd_pkg::COORD_W-1:0] y;
    logic [bctd_pkg::CHAN_W-1:0]  r;
    logic [bctd_pkg::CHAN_W-1:0]  g;
    logic [bctd_pkg::CHAN_W-1:0]  b;
    logic [bctd_pkg::CHAN_W-1:0]  a;
    logic                         last;
  } texel_t;

  logic clk;
  logic rst;

  bctd_cfg_if   cfg ();
  bctd_word_if  blocks ();
  bctd_texel_if texels ();

  bc_texture_block_decoder_core #(.MAX_IMAGE_DIM(MAX_DIM)) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .blocks (blocks),
    .texels (texels)
  );

  // decoder shadow state
  logic [bctd_pkg::MODE_W-1:0] cur_fmt;
  int                          cur_w;
  int                          cur_h;
  logic [63:0]                 held_first;
  bit                          have_first;
  int                          blk_col;
  int                          blk_row;

  logic [63:0] word_q[$];
  texel_t      texel_q[$];
  int          mismatches;
  int          cycle_count;
  int          tx_gap;
  int          tx_quiet;
  int          rx_gap;
  int          rx_quiet;
  logic        rx_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // idle length: mostly none, some short, a few long, with quiet runs
  function automatic int pick_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic int dim_clamp(int v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // 8- or 6-step ramp between two 8-bit endpoints
  function automatic logic [bctd_pkg::CHAN_W-1:0] ramp8(logic [63:0] w, int t);
    int a0;
    int a1;
    int k;
    a0 = int'(w[7:0]);
    a1 = int'(w[15:8]);
    k  = int'((w >> (16 + 3 * t)) & 64'h7);
    if (k == 0) return bctd_pkg::CHAN_W'(a0);
    if (k == 1) return bctd_pkg::CHAN_W'(a1);
    if (a0 > a1) return bctd_pkg::CHAN_W'(((8 - k) * a0 + (k - 1) * a1) / 7);
    if (k >= 6) return (k == 6) ? 8'd0 : 8'd255;
    return bctd_pkg::CHAN_W'(((6 - k) * a0 + (k - 1) * a1) / 5);
  endfunction

  // one channel of the rgb565 palette; ch 0 red, 1 green, 2 blue
  function automatic logic [bctd_pkg::CHAN_W-1:0] ramp565(logic [63:0] w, int t, bit four,
                                                          int ch);
    int c0;
    int c1;
    int e0;
    int e1;
    int sel;
    c0  = int'(w[15:0]);
    c1  = int'(w[31:16]);
    sel = int'((w >> (32 + 2 * t)) & 64'h3);
    case (ch)
      0: begin
        e0 = ((c0 >> 11) & 31) << 3;
        e1 = ((c1 >> 11) & 31) << 3;
      end
      1: begin
        e0 = ((c0 >> 5) & 63) << 2;
        e1 = ((c1 >> 5) & 63) << 2;
      end
      default: begin
        e0 = (c0 & 31) << 3;
        e1 = (c1 & 31) << 3;
      end
    endcase
    if (sel == 0) return bctd_pkg::CHAN_W'(e0);
    if (sel == 1) return bctd_pkg::CHAN_W'(e1);
    if (c0 > c1 || four) begin
      if (sel == 2) return bctd_pkg::CHAN_W'((2 * e0 + e1 + 1) / 3);
      return bctd_pkg::CHAN_W'((e0 + 2 * e1 + 1) / 3);
    end
    if (sel == 2) return bctd_pkg::CHAN_W'((e0 + e1 + 1) >> 1);
    return '0;
  endfunction

  // register write as seen by the shadow state
  function automatic void apply_reg(logic [bctd_pkg::CFG_IDX_W-1:0]  idx,
                                    logic [bctd_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bctd_pkg::REG_FORMAT_MODE:  cur_fmt = val[bctd_pkg::MODE_W-1:0];
      bctd_pkg::REG_IMAGE_WIDTH:  cur_w = int'(val);
      bctd_pkg::REG_IMAGE_HEIGHT: cur_h = int'(val);
      default:                    return;
    endcase
    held_first = '0;
    have_first = 1'b0;
    blk_col    = 0;
    blk_row    = 0;
  endfunction

  // expected texels for one accepted word, in emit order
  function automatic void decode_word(logic [63:0] word);
    logic [63:0] lo;
    logic [63:0] hi;
    int          w;
    int          h;
    int          x0;
    int          y0;
    int          cw;
    int          ch;
    int          t;
    texel_t      tx;
    if (cur_fmt > bctd_pkg::MODE_LATC2) return;
    if (cur_fmt == bctd_pkg::MODE_DXT3 || cur_fmt == bctd_pkg::MODE_DXT5 ||
        cur_fmt == bctd_pkg::MODE_LATC2) begin
      if (!have_first) begin
        held_first = word;
        have_first = 1'b1;
        return;
      end
      have_first = 1'b0;
      lo = held_first;
      hi = word;
    end else begin
      lo = word;
      hi = word;
    end
    w  = dim_clamp(cur_w);
    h  = dim_clamp(cur_h);
    x0 = blk_col * 4;
    y0 = blk_row * 4;
    cw = (w - x0 < 4) ? w - x0 : 4;
    ch = (h - y0 < 4) ? h - y0 : 4;
    for (int yy = 0; yy < ch; yy++) begin
      for (int xx = 0; xx < cw; xx++) begin
        t    = yy * 4 + xx;
        tx.r = '0;
        tx.g = '0;
        tx.b = '0;
        tx.a = '0;
        case (cur_fmt)
          bctd_pkg::MODE_DXT1: begin
            tx.r = ramp565(lo, t, 1'b0, 0);
            tx.g = ramp565(lo, t, 1'b0, 1);
            tx.b = ramp565(lo, t, 1'b0, 2);
            tx.a = 8'd255;
          end
          bctd_pkg::MODE_DXT3: begin
            tx.r = ramp565(hi, t, 1'b1, 0);
            tx.g = ramp565(hi, t, 1'b1, 1);
            tx.b = ramp565(hi, t, 1'b1, 2);
            tx.a = bctd_pkg::CHAN_W'(int'((lo >> (4 * t)) & 64'hF) * 17);
          end
          bctd_pkg::MODE_DXT5: begin
            tx.r = ramp565(hi, t, 1'b1, 0);
            tx.g = ramp565(hi, t, 1'b1, 1);
            tx.b = ramp565(hi, t, 1'b1, 2);
            tx.a = ramp8(lo, t);
          end
          bctd_pkg::MODE_LATC1: begin
            tx.r = ramp8(lo, t);
          end
          default: begin
            tx.r = ramp8(hi, t);
            tx.g = ramp8(lo, t);
          end
        endcase
        tx.x    = bctd_pkg::COORD_W'(x0 + xx);
        tx.y    = bctd_pkg::COORD_W'(y0 + yy);
        tx.last = (yy == ch - 1) && (xx == cw - 1);
        texel_q.push_back(tx);
      end
    end
    blk_col++;
    if (blk_col >= (w + 3) / 4) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= (h + 3) / 4) blk_row = 0;
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t texel %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // random block word, biased toward equal endpoints and flat bytes
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: w[15:8] = w[7:0];
      1: w[31:16] = w[15:0];
      2: w = '0;
      3: w = '1;
      4: w[31:0] = {w[15:0], w[31:16]};
      default: ;
    endcase
    return w;
  endfunction

  // word driver: pops pending words, predicts on each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      blocks.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (blocks.valid && blocks.ready) decode_word(blocks.block_word);
      if (!blocks.valid || blocks.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          blocks.valid <= 1'b0;
        end else if (word_q.size() > 0) begin
          blocks.valid      <= 1'b1;
          blocks.block_word <= word_q.pop_front();
          tx_gap = pick_gap(tx_quiet);
        end else begin
          blocks.valid <= 1'b0;
        end
      end
    end
  end

  // texel monitor: compares each beat with the oldest expected texel
  always @(posedge clk) begin
    texel_t want;
    if (rst) begin
      texels.ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (texels.valid && texels.ready) begin
        if (texel_q.size() == 0) begin
          $display("%0t unexpected texel: expected none, got x=%0d y=%0d", $time,
                   texels.texel_x, texels.texel_y);
          mismatches++;
        end else begin
          want = texel_q.pop_front();
          check_field("x", 32'(want.x), 32'(texels.texel_x));
          check_field("y", 32'(want.y), 32'(texels.texel_y));
          check_field("red_or_lum", 32'(want.r), 32'(texels.chan_red_or_lum));
          check_field("green_or_second", 32'(want.g), 32'(texels.chan_green_or_second));
          check_field("blue", 32'(want.b), 32'(texels.chan_blue));
          check_field("alpha", 32'(want.a), 32'(texels.chan_alpha));
          check_field("block_last", 32'(want.last), 32'(texels.block_last));
        end
        rx_gap = pick_gap(rx_quiet);
      end
      if (rx_hold) begin
        texels.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        texels.ready <= 1'b0;
      end else begin
        texels.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_bc_texture_block_decoder_core failed");
      $finish;
    end
  end

  // wait until nothing is pending or expected, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (word_q.size() != 0 || blocks.valid || texel_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [bctd_pkg::CFG_IDX_W-1:0]  idx,
                           logic [bctd_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk);
    while (!cfg.ready);
    apply_reg(idx, val);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_image(logic [bctd_pkg::MODE_W-1:0] mode, int w, int h);
    wait_idle();
    write_reg(bctd_pkg::REG_FORMAT_MODE, bctd_pkg::CFG_DATA_W'(mode));
    write_reg(bctd_pkg::REG_IMAGE_WIDTH, bctd_pkg::CFG_DATA_W'(w));
    write_reg(bctd_pkg::REG_IMAGE_HEIGHT, bctd_pkg::CFG_DATA_W'(h));
  endtask

  // one random phase; optionally pause the sender or hold off the receiver
  task automatic run_phase(logic [bctd_pkg::MODE_W-1:0] mode, int w, int h, int n,
                           bit pause_mid, bit hold_rx);
    set_image(mode, w, h);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_idle();
      word_q.push_back(rand_word());
    end
    if (hold_rx) begin
      @(posedge clk);
      rx_hold <= 1'b1;
      repeat (RX_HOLD_LEN) @(posedge clk);
      rx_hold <= 1'b0;
    end
    wait_idle();
  endtask

  initial begin
    rst               = 1'b1;
    cfg.valid         = 1'b0;
    cfg.index         = '0;
    cfg.data          = '0;
    blocks.valid      = 1'b0;
    blocks.block_word = '0;
    texels.ready      = 1'b0;
    rx_hold           = 1'b0;
    mismatches        = 0;
    cycle_count       = 0;
    tx_quiet          = 0;
    rx_quiet          = 0;
    cur_fmt           = bctd_pkg::MODE_DXT1;
    cur_w             = 4;
    cur_h             = 4;
    held_first        = '0;
    have_first        = 1'b0;
    blk_col           = 0;
    blk_row           = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // dxt1 at reset settings: one block per image, so the walk wraps every word
    word_q.push_back(64'h0);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    word_q.push_back(64'hE4E4_E4E4_001F_F800);
    word_q.push_back(64'h1B1B_1B1B_F800_07E0);
    word_q.push_back(64'hA5A5_5A5A_8410_8410);

    // dxt3, mode written with junk upper bits; second block clipped
    set_image(bctd_pkg::MODE_DXT3, 6, 5);
    write_reg(bctd_pkg::REG_FORMAT_MODE,
              13'h1FF8 | bctd_pkg::CFG_DATA_W'(bctd_pkg::MODE_DXT3));
    word_q.push_back(64'hFEDC_BA98_7654_3210);
    word_q.push_back(64'hE4E4_E4E4_FFFF_0000);
    word_q.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    word_q.push_back(64'h0);

    // dxt5: all alpha codes both ramps, equal endpoints, then a dangling first word
    set_image(bctd_pkg::MODE_DXT5, 9, 4);
    word_q.push_back(64'hFAC6_88FA_C688_10F0);
    word_q.push_back(64'h4E4E_B1B1_07E0_F81F);
    word_q.push_back(64'hFAC6_88FA_C688_F010);
    word_q.push_back(64'h1B1B_E4E4_F81F_07E0);
    word_q.push_back(64'hFAC6_88FA_C688_7777);
    word_q.push_back(64'h0);
    word_q.push_back(64'h1234_5678_9ABC_DEF0);

    // latc1 with width below range and height above range
    set_image(bctd_pkg::MODE_LATC1, 0, 8191);
    word_q.push_back(64'hFAC6_88FA_C688_10F0);
    word_q.push_back(64'hFAC6_88FA_C688_F010);

    // latc2; an unknown register write keeps the held first word
    set_image(bctd_pkg::MODE_LATC2, 4, 4);
    word_q.push_back(64'hFAC6_88FA_C688_F010);
    word_q.push_back(64'h0123_4567_89AB_CDEF);
    word_q.push_back(64'hFAC6_88FA_C688_10F0);
    wait_idle();
    write_reg(REG_SPARE, 13'h1ABC);
    word_q.push_back(64'hC688_FAC6_88FA_FF00);

    // unused format: words ignored
    set_image(MODE_SPARE_6, 4, 4);
    word_q.push_back(64'hDEAD_BEEF_0BAD_F00D);
    word_q.push_back(64'h0);

    // random phases
    run_phase(bctd_pkg::MODE_DXT1, 13, 9, 40, 1'b1, 1'b0);
    run_phase(bctd_pkg::MODE_DXT3, 7, 6, 41, 1'b0, 1'b0);
    run_phase(bctd_pkg::MODE_DXT5, 4096, 4096, 30, 1'b0, 1'b1);
    run_phase(bctd_pkg::MODE_LATC1, 1, 1, 20, 1'b0, 1'b0);
    run_phase(bctd_pkg::MODE_LATC2, 3, 10, 31, 1'b0, 1'b0);
    run_phase(MODE_SPARE_7, 5, 5, 6, 1'b0, 1'b0);
    run_phase(bctd_pkg::MODE_DXT1, 4096, 1, 12, 1'b0, 1'b0);
    run_phase(bctd_pkg::MODE_W'($urandom_range(bctd_pkg::MODE_DXT1, bctd_pkg::MODE_LATC2)),
              $urandom_range(1, 12), $urandom_range(1, 12), 40, 1'b0, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && texel_q.size() == 0) begin
      $display("tb_bc_texture_block_decoder_core passed");
    end else begin
      $display("tb_bc_texture_block_decoder_core failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bctd_pkg.sv
rtl/core/bctd_if.sv
rtl/core/bctd_walker.sv
rtl/core/bctd_emitter.sv
rtl/core/bc_texture_block_decoder_core.sv
sim/tb_bc_texture_block_decoder_core.sv
